// ===== src/lch_pkg.sv =====
// shared types, codes and helpers for the lossy counting heavy hitters core
package lch_pkg;

   localparam int COUNT_W = 32;

   // request function codes
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_QUERY  = 2'd1;
   localparam logic [1:0] FUNC_REPORT = 2'd2;

   // response kinds
   localparam logic [2:0] KIND_INSERT_DONE  = 3'd0;
   localparam logic [2:0] KIND_OVERFLOW     = 3'd1;
   localparam logic [2:0] KIND_ESTIMATE     = 3'd2;
   localparam logic [2:0] KIND_REPORT_ITEM  = 3'd3;
   localparam logic [2:0] KIND_REPORT_EMPTY = 3'd4;

   // register indexes
   localparam logic CSR_WINDOW_SIZE     = 1'b0;
   localparam logic CSR_REPORT_FRACTION = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE_PREP,
      ST_MERGE,
      ST_MERGE_FLUSH,
      ST_SCAN_PREP,
      ST_SCAN
   } state_type;

   typedef enum logic [1:0] {
      JOB_INSERT,
      JOB_QUERY,
      JOB_REPORT
   } job_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] delta;
   } cnt_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + COUNT_W'(1);
   endfunction

   function automatic logic [COUNT_W:0] sum_wide(input cnt_type c);
      return {1'b0, c.count} + {1'b0, c.delta};
   endfunction

   function automatic logic [COUNT_W-1:0] sat_sum(input cnt_type c);
      logic [COUNT_W:0] s;
      s = sum_wide(c);
      return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
   endfunction

endpackage

// ===== src/lch_cell.sv =====
// one cell of the sorted window chain: sorted insert and shift toward the head
module lch_cell import lch_pkg::*; #(
   parameter int KEY_W = 32
) (
   input  logic             clock,
   input  cell_op_type      op,
   input  logic [KEY_W-1:0] new_key,
   input  logic [KEY_W-1:0] left_key,
   input  logic             left_gt,
   input  logic [KEY_W-1:0] right_key,
   input  logic             occupied,
   output logic [KEY_W-1:0] key_out,
   output logic             gt_out
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;

   // an empty cell counts as greater, so the new key lands at the first such slot
   assign gt_out  = !occupied || (key_ff > new_key);
   assign key_out = key_ff;

   // next key
   always_comb begin
      case (op)
         CELL_INSERT: begin
            if (!gt_out) key_in = key_ff;
            else if (left_gt) key_in = left_key;
            else key_in = new_key;
         end
         CELL_SHIFT: key_in = right_key;
         default:    key_in = key_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// ===== src/lch_table.sv =====
// ping-pong counter table: two banks of key, count and delta, registered read
module lch_table import lch_pkg::*; #(
   parameter int KEY_W   = 32,
   parameter int ENTRIES = 64
) (
   input  logic                       clock,
   input  logic                       rd_bank,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [KEY_W-1:0]           rd_key,
   output cnt_type                    rd_cnt,
   input  logic                       wr_en,
   input  logic                       wr_bank,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [KEY_W-1:0]           wr_key,
   input  cnt_type                    wr_cnt
);

   logic [KEY_W-1:0] key_mem [2*ENTRIES];
   cnt_type          cnt_mem [2*ENTRIES];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[{wr_bank, wr_addr}] <= wr_key;
         cnt_mem[{wr_bank, wr_addr}] <= wr_cnt;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      rd_key <= key_mem[{rd_bank, rd_addr}];
      rd_cnt <= cnt_mem[{rd_bank, rd_addr}];
   end

endmodule

// ===== src/lossy_counting_heavy_hitters_core.sv =====
// top level of the lossy counting heavy hitters core
// An insert that does not fill the window is answered in the cycle after it is accepted;
// the window is a chain of cells kept sorted as keys arrive. The insert that fills the
// window runs a merge walk of window keys and table entries, one element per cycle through
// the single table read port before its response.
// A query scans the table one entry per cycle. A report merges the partial window and,
// unless the table overflows, then scans it, emitting one word per listed entry.
// Responses are single-cycle strobes on rsp_valid; the receiver must take every word.
module lossy_counting_heavy_hitters_core import lch_pkg::*; #(
   parameter int WINDOW_MAX    = 32,
   parameter int TABLE_ENTRIES = 64,
   parameter int KEY_BITS      = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_key,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_item_key,
   output logic [31:0] rsp_estimate,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   localparam int FILL_W = $clog2(WINDOW_MAX + 1);
   localparam int TAB_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int AW     = $clog2(TABLE_ENTRIES);

   // key width adaption at the ports
   logic [KEY_BITS-1:0] key_w;
   logic [KEY_BITS-1:0] rsp_key_ff, rsp_key_in;

   generate
      if (KEY_BITS > 32) begin : g_key_wide
         assign key_w        = {{(KEY_BITS-32){1'b0}}, req_key};
         assign rsp_item_key = rsp_key_ff[31:0];
      end else if (KEY_BITS == 32) begin : g_key_same
         assign key_w        = req_key;
         assign rsp_item_key = rsp_key_ff;
      end else begin : g_key_narrow
         assign key_w        = req_key[KEY_BITS-1:0];
         assign rsp_item_key = {{(32-KEY_BITS){1'b0}}, rsp_key_ff};
      end
   endgenerate

   state_type state_ff, state_in;
   job_type   job_ff, job_in;

   logic [5:0]          ws_ff;
   logic [15:0]         frac_ff;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [31:0]         epoch_ff, epoch_in;
   logic [31:0]         stream_ff, stream_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [TAB_W-1:0]    size_ff, size_in;
   logic                bank_ff, bank_in;
   logic [31:0]         wdelta_ff, wdelta_in;
   logic [31:0]         ecmp_ff, ecmp_in;
   logic [FILL_W-1:0]   l_ff, l_in, i_ff, i_in;
   logic [TAB_W-1:0]    j_ff, j_in, m_ff, m_in;
   logic                ovf_ff, ovf_in;
   logic                acc_v_ff, acc_v_in;
   logic [KEY_BITS-1:0] acc_key_ff, acc_key_in;
   cnt_type             acc_cnt_ff, acc_cnt_in;
   logic                pend_v_ff, pend_v_in;
   logic [KEY_BITS-1:0] pend_key_ff, pend_key_in;
   logic [31:0]         pend_est_ff, pend_est_in;
   logic [47:0]         thr_ff, thr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_kind_ff, rsp_kind_in;
   logic [31:0]         rsp_est_ff, rsp_est_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic [FILL_W-1:0]   eff_window;
   logic [FILL_W-1:0]   fill_next;
   logic                ins_merge;
   logic                w_avail, t_avail, elem, take_tab, match, emit, keep, we;
   logic                qualify, hit;
   logic [KEY_BITS-1:0] head_key, e_key, rd_key;
   cnt_type             e_cnt, rd_cnt;
   cell_op_type         cell_op;
   logic [KEY_BITS-1:0] cell_key [WINDOW_MAX];
   logic                cell_gt [WINDOW_MAX];

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;

   // effective window size, clamped to the legal range
   always_comb begin
      if (int'(ws_ff) < 2) eff_window = FILL_W'(2);
      else if (int'(ws_ff) > WINDOW_MAX) eff_window = FILL_W'(WINDOW_MAX);
      else eff_window = FILL_W'(ws_ff);
   end

   assign fill_next = (fill_ff < FILL_W'(WINDOW_MAX)) ? fill_ff + FILL_W'(1) : fill_ff;
   assign ins_merge = (fill_next >= eff_window);

   // merge walk decisions
   assign head_key = cell_key[0];
   assign w_avail  = (i_ff < l_ff);
   assign t_avail  = (j_ff < size_ff);
   assign elem     = w_avail || t_avail;
   assign take_tab = t_avail && (!w_avail || (rd_key <= head_key));
   assign e_key    = take_tab ? rd_key : head_key;
   assign e_cnt    = take_tab ? rd_cnt : cnt_type'{count: 32'd1, delta: wdelta_ff};
   assign match    = acc_v_ff && (acc_key_ff == e_key);
   assign emit     = ((state_ff == ST_MERGE) && elem && !match) || (state_ff == ST_MERGE_FLUSH);
   assign keep     = sum_wide(acc_cnt_ff) > {1'b0, ecmp_ff};
   assign we       = emit && acc_v_ff && keep && (m_ff < TAB_W'(TABLE_ENTRIES));

   // scan decisions
   assign qualify = t_avail && ({sum_wide(rd_cnt), 16'd0} > {1'b0, thr_ff});
   assign hit     = t_avail && (rd_key == key_ff);

   // window chain control
   always_comb begin
      if (accept && (req_func == FUNC_INSERT) && (fill_ff < FILL_W'(WINDOW_MAX)))
         cell_op = CELL_INSERT;
      else if ((state_ff == ST_MERGE) && elem && !take_tab)
         cell_op = CELL_SHIFT;
      else
         cell_op = CELL_HOLD;
   end

   // sorted window chain
   for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
      logic [KEY_BITS-1:0] left_key, right_key;
      logic                left_gt;
      if (g == 0) begin : g_head
         assign left_key = '0;
         assign left_gt  = 1'b0;
      end else begin : g_body
         assign left_key = cell_key[g-1];
         assign left_gt  = cell_gt[g-1];
      end
      if (g == WINDOW_MAX - 1) begin : g_tail
         assign right_key = '0;
      end else begin : g_inner
         assign right_key = cell_key[g+1];
      end
      lch_cell #(.KEY_W(KEY_BITS)) u_cell (
         .clock     (clock),
         .op        (cell_op),
         .new_key   (key_w),
         .left_key  (left_key),
         .left_gt   (left_gt),
         .right_key (right_key),
         .occupied  (FILL_W'(g) < fill_ff),
         .key_out   (cell_key[g]),
         .gt_out    (cell_gt[g])
      );
   end

   // counter table
   lch_table #(.KEY_W(KEY_BITS), .ENTRIES(TABLE_ENTRIES)) u_table (
      .clock   (clock),
      .rd_bank (bank_ff),
      .rd_addr (j_in[AW-1:0]),
      .rd_key  (rd_key),
      .rd_cnt  (rd_cnt),
      .wr_en   (we),
      .wr_bank (!bank_ff),
      .wr_addr (m_ff[AW-1:0]),
      .wr_key  (acc_key_ff),
      .wr_cnt  (acc_cnt_ff)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_INSERT: state_in = ins_merge ? ST_MERGE_PREP : ST_IDLE;
                  FUNC_QUERY:  state_in = ST_SCAN_PREP;
                  FUNC_REPORT: state_in = ST_MERGE_PREP;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_MERGE_PREP: state_in = ST_MERGE;
         ST_MERGE:      state_in = elem ? ST_MERGE : ST_MERGE_FLUSH;
         ST_MERGE_FLUSH: begin
            state_in = ((job_ff == JOB_REPORT) && !ovf_ff) ? ST_SCAN_PREP : ST_IDLE;
         end
         ST_SCAN_PREP: state_in = ST_SCAN;
         ST_SCAN: begin
            if (!t_avail || ((job_ff == JOB_QUERY) && hit)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and response
   always_comb begin
      job_in       = job_ff;
      key_in       = key_ff;
      epoch_in     = epoch_ff;
      stream_in    = stream_ff;
      fill_in      = fill_ff;
      size_in      = size_ff;
      bank_in      = bank_ff;
      wdelta_in    = wdelta_ff;
      ecmp_in      = ecmp_ff;
      l_in         = l_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      m_in         = m_ff;
      ovf_in       = ovf_ff;
      acc_v_in     = acc_v_ff;
      acc_key_in   = acc_key_ff;
      acc_cnt_in   = acc_cnt_ff;
      pend_v_in    = pend_v_ff;
      pend_key_in  = pend_key_ff;
      pend_est_in  = pend_est_ff;
      thr_in       = thr_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_est_in   = rsp_est_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_INSERT: begin
                     stream_in = sat_inc(stream_ff);
                     key_in    = key_w;
                     fill_in   = fill_next;
                     job_in    = JOB_INSERT;
                     if (ins_merge) begin
                        epoch_in  = sat_inc(epoch_ff);
                        wdelta_in = epoch_ff;
                        ecmp_in   = sat_inc(epoch_ff);
                        l_in      = fill_next;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_INSERT_DONE;
                        rsp_key_in   = key_w;
                        rsp_est_in   = '0;
                        rsp_last_in  = 1'b1;
                     end
                  end
                  FUNC_QUERY: begin
                     key_in = key_w;
                     job_in = JOB_QUERY;
                  end
                  FUNC_REPORT: begin
                     job_in    = JOB_REPORT;
                     thr_in    = frac_ff * stream_ff;
                     wdelta_in = epoch_ff;
                     ecmp_in   = epoch_ff;
                     l_in      = fill_ff;
                  end
                  default: job_in = job_ff;
               endcase
            end
         end
         ST_MERGE_PREP: begin
            ovf_in   = (int'(l_ff) + int'(size_ff)) > TABLE_ENTRIES;
            i_in     = '0;
            j_in     = '0;
            m_in     = '0;
            acc_v_in = 1'b0;
         end
         ST_MERGE: begin
            if (elem) begin
               if (take_tab) j_in = j_ff + TAB_W'(1);
               else i_in = i_ff + FILL_W'(1);
               if (match) begin
                  acc_cnt_in.count = sat_inc(acc_cnt_ff.count);
               end else begin
                  acc_v_in   = 1'b1;
                  acc_key_in = e_key;
                  acc_cnt_in = e_cnt;
               end
               m_in = m_ff + TAB_W'(we);
            end
         end
         ST_MERGE_FLUSH: begin
            size_in = m_ff + TAB_W'(we);
            bank_in = !bank_ff;
            fill_in = '0;
            if (job_ff == JOB_INSERT) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = ovf_ff ? KIND_OVERFLOW : KIND_INSERT_DONE;
               rsp_key_in   = key_ff;
               rsp_est_in   = '0;
               rsp_last_in  = 1'b1;
            end else if (ovf_ff) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_OVERFLOW;
               rsp_key_in   = '0;
               rsp_est_in   = '0;
               rsp_last_in  = 1'b1;
            end
         end
         ST_SCAN_PREP: begin
            j_in      = '0;
            pend_v_in = 1'b0;
         end
         ST_SCAN: begin
            if (!t_avail) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (job_ff == JOB_QUERY) begin
                  rsp_kind_in = KIND_ESTIMATE;
                  rsp_key_in  = key_ff;
                  rsp_est_in  = '0;
               end else if (pend_v_ff) begin
                  rsp_kind_in = KIND_REPORT_ITEM;
                  rsp_key_in  = pend_key_ff;
                  rsp_est_in  = pend_est_ff;
               end else begin
                  rsp_kind_in = KIND_REPORT_EMPTY;
                  rsp_key_in  = '0;
                  rsp_est_in  = '0;
               end
            end else if (job_ff == JOB_QUERY) begin
               j_in = j_ff + TAB_W'(1);
               if (hit) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_ESTIMATE;
                  rsp_key_in   = key_ff;
                  rsp_est_in   = sat_sum(rd_cnt);
                  rsp_last_in  = 1'b1;
               end
            end else begin
               j_in = j_ff + TAB_W'(1);
               if (qualify) begin
                  // hold the newest hit back so the final word can carry last
                  if (pend_v_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_REPORT_ITEM;
                     rsp_key_in   = pend_key_ff;
                     rsp_est_in   = pend_est_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_v_in   = 1'b1;
                  pend_key_in = rd_key;
                  pend_est_in = sat_sum(rd_cnt);
               end
            end
         end
         default: job_in = job_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= JOB_INSERT;
         ws_ff        <= 6'd32;
         frac_ff      <= '0;
         epoch_ff     <= '0;
         stream_ff    <= '0;
         fill_ff      <= '0;
         size_ff      <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_v_ff     <= 1'b0;
         pend_v_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         epoch_ff     <= epoch_in;
         stream_ff    <= stream_in;
         fill_ff      <= fill_in;
         size_ff      <= size_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_v_ff     <= acc_v_in;
         pend_v_ff    <= pend_v_in;
         ovf_ff       <= ovf_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_SIZE:     ws_ff   <= csr_data[5:0];
               CSR_REPORT_FRACTION: frac_ff <= csr_data;
               default:             ws_ff   <= ws_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      wdelta_ff   <= wdelta_in;
      ecmp_ff     <= ecmp_in;
      l_ff        <= l_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      m_ff        <= m_in;
      acc_key_ff  <= acc_key_in;
      acc_cnt_ff  <= acc_cnt_in;
      pend_key_ff <= pend_key_in;
      pend_est_ff <= pend_est_in;
      thr_ff      <= thr_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_estimate = rsp_est_ff;
   assign rsp_last     = rsp_last_ff;

   // table never grows past its depth
   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      size_ff <= TAB_W'(TABLE_ENTRIES))
      else $error("table size beyond depth");

   // the window never sits full while idle
   a_fill_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (fill_ff < FILL_W'(WINDOW_MAX)))
      else $error("window full while idle");

   // the merge walk never reads past the window
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (i_ff <= l_ff))
      else $error("merge walk past window");

   // an empty report word always closes the report
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_REPORT_EMPTY)) |-> rsp_last)
      else $error("empty report without last");

endmodule
